FILE: hw/rtl/lcdts_pkg.sv
// Shared types, codes and timing constants for the LCD line timing and STAT block.
// Used by every module under hw/rtl; depends on nothing.
package lcdts_pkg;

	localparam int LINE_CYCLES_DEF   = 456;
	localparam int VISIBLE_LINES_DEF = 144;
	localparam int LAST_LINE_DEF     = 153;

	localparam int OAM_TIME  = 80;
	localparam int XFER_TIME = (168 + 291) / 2;

	localparam int CNT_W = 10;
	localparam int CALC_W = CNT_W + 1;

	localparam logic [7:0] CTRL_ENABLE_MASK = 8'h80;
	localparam logic [7:0] STAT_FIXED_BITS  = 8'h80;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CTRL    = 2'd0,
		REG_STATUS  = 2'd1,
		REG_LINE    = 2'd2,
		REG_COMPARE = 2'd3
	} reg_sel_t;

	typedef enum logic [1:0] {
		DM_HBLANK = 2'd0,
		DM_VBLANK = 2'd1,
		DM_OAM    = 2'd2,
		DM_XFER   = 2'd3
	} disp_mode_t;

	localparam int EN_HBLANK = 0;
	localparam int EN_VBLANK = 1;
	localparam int EN_OAM    = 2;
	localparam int EN_MATCH  = 3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] cycles;
		logic [1:0] reg_sel;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       vblank_irq;
		logic       stat_irq;
	} result_t;

endpackage

FILE: hw/rtl/lcdts_in_stage.sv
// Input register stage of the LCD line timing block.
// Unpacks the slave-side stream into an item; depends on lcdts_pkg.
module lcdts_in_stage
	import lcdts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [3:0]  s_tuser,
	input  logic        advance,
	output logic        valid_s1,
	output item_t       item_s1
);

	logic valid_q;

	assign s_tready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode       <= s_tuser[1:0];
			item_s1.reg_sel    <= s_tuser[3:2];
			item_s1.cycles     <= s_tdata[7:0];
			item_s1.write_data <= s_tdata[15:8];
		end
	end

endmodule

FILE: hw/rtl/lcdts_engine.sv
// Line countdown, mode sequencing, register file and STAT interrupt logic.
// Holds the countdown, line, mode and register state and forms one result per item; depends on lcdts_pkg.
module lcdts_engine
	import lcdts_pkg::*;
#(
	parameter int LINE_CYCLES   = LINE_CYCLES_DEF,
	parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
	parameter int LAST_LINE     = LAST_LINE_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	localparam logic signed [CALC_W-1:0] LINE_S = CALC_W'(LINE_CYCLES);
	localparam logic signed [CALC_W-1:0] OAM_END_S = CALC_W'(LINE_CYCLES - OAM_TIME);
	localparam logic signed [CALC_W-1:0] XFER_END_S =
		CALC_W'(LINE_CYCLES - OAM_TIME - XFER_TIME);
	localparam logic [8:0] VISIBLE_W = 9'(VISIBLE_LINES);
	localparam logic [8:0] LAST_W    = 9'(LAST_LINE);

	logic [CNT_W-1:0] cycles_left_q, cycles_left_d;
	logic [7:0]       line_q, line_d;
	logic [1:0]       dmode_q, dmode_d;
	logic [7:0]       ctrl_q, ctrl_d;
	logic [3:0]       enables_q, enables_d;
	logic [7:0]       compare_q, compare_d;

	logic signed [CALC_W-1:0] cl_dec;
	logic signed [CALC_W-1:0] cl_wrap;
	logic [8:0]               next_line;

	always_comb begin
		cycles_left_d = cycles_left_q;
		line_d        = line_q;
		dmode_d       = dmode_q;
		ctrl_d        = ctrl_q;
		enables_d     = enables_q;
		compare_d     = compare_q;
		res           = '0;
		cl_dec        = $signed({1'b0, cycles_left_q}) - $signed({3'b000, item.cycles});
		cl_wrap       = cl_dec + LINE_S;
		next_line     = {1'b0, line_q} + 9'd1;

		case (item.mode)
			OP_TICK: begin
				if ((ctrl_q & CTRL_ENABLE_MASK) != 8'h00) begin
					cycles_left_d = cl_dec[CNT_W-1:0];
					if (dmode_q == DM_OAM || dmode_q == DM_XFER) begin
						if (cl_dec >= OAM_END_S) begin
							dmode_d = dmode_q;
						end else if (cl_dec >= XFER_END_S) begin
							dmode_d = DM_XFER;
						end else begin
							dmode_d = DM_HBLANK;
							if (enables_q[EN_HBLANK]) begin
								res.stat_irq = 1'b1;
							end
						end
					end
					if (cl_dec <= 0) begin
						cycles_left_d = cl_wrap[CNT_W-1:0];
						if (enables_q[EN_MATCH] && next_line == {1'b0, compare_q}) begin
							res.stat_irq = 1'b1;
						end
						line_d = next_line[7:0];
						if (next_line == VISIBLE_W) begin
							res.vblank_irq = 1'b1;
							dmode_d = DM_VBLANK;
							if (enables_q[EN_VBLANK]) begin
								res.stat_irq = 1'b1;
							end
						end else if (next_line > LAST_W || next_line[8]) begin
							line_d  = 8'd0;
							dmode_d = DM_OAM;
							if (enables_q[EN_OAM]) begin
								res.stat_irq = 1'b1;
							end
						end else if (next_line < VISIBLE_W) begin
							dmode_d = DM_OAM;
							if (enables_q[EN_OAM]) begin
								res.stat_irq = 1'b1;
							end
						end
					end
				end
			end
			OP_READ: begin
				case (item.reg_sel)
					REG_CTRL:    res.read_data = ctrl_q;
					REG_STATUS:  res.read_data = STAT_FIXED_BITS | {1'b0, enables_q, 3'b000}
						| {5'b00000, (line_q == compare_q), dmode_q};
					REG_LINE:    res.read_data = line_q;
					REG_COMPARE: res.read_data = compare_q;
					default:     res.read_data = 8'h00;
				endcase
			end
			OP_WRITE: begin
				case (item.reg_sel)
					REG_CTRL: begin
						ctrl_d = item.write_data;
						if ((item.write_data & CTRL_ENABLE_MASK) == 8'h00) begin
							cycles_left_d = CNT_W'(LINE_CYCLES);
							dmode_d       = DM_HBLANK;
							line_d        = 8'd0;
						end
					end
					REG_STATUS:  enables_d = item.write_data[6:3];
					REG_LINE:    line_d = 8'd0;
					REG_COMPARE: compare_d = item.write_data;
					default:     compare_d = compare_q;
				endcase
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_left_q <= CNT_W'(LINE_CYCLES);
			line_q        <= 8'd0;
			dmode_q       <= DM_HBLANK;
			ctrl_q        <= 8'd0;
			enables_q     <= 4'd0;
			compare_q     <= 8'd0;
		end else if (fire) begin
			cycles_left_q <= cycles_left_d;
			line_q        <= line_d;
			dmode_q       <= dmode_d;
			ctrl_q        <= ctrl_d;
			enables_q     <= enables_d;
			compare_q     <= compare_d;
		end
	end

endmodule

FILE: hw/rtl/lcdts_out_stage.sv
// Result register of the LCD line timing block.
// Packs one result onto the master-side stream; depends on lcdts_pkg.
module lcdts_out_stage
	import lcdts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_valid,
	input  result_t     res,
	output logic        can_load,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {6'b000000, res_q.stat_irq, res_q.vblank_irq, res_q.read_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load_valid) begin
			res_q <= res;
		end
	end

endmodule

FILE: hw/rtl/lcd_line_timing_stat_core.sv
// An accepted input transaction is held in the input register and its result in the result register,
// which drives the master side. Throughput: one transaction per cycle unless the master side stalls;
// the state update is a single registered pass between the input register and the result register.
// Reset: arst_n clears both stream stages and sets the line countdown to a full line,
// line, mode, control, enables and compare to zero, so the display starts disabled.
module lcd_line_timing_stat_core
	import lcdts_pkg::*;
#(
	parameter int LINE_CYCLES   = LINE_CYCLES_DEF,
	parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
	parameter int LAST_LINE     = LAST_LINE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // cycles[7:0], write_data[15:8]
	input  logic [3:0]  s_tuser,  // mode[1:0], reg_sel[3:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // read_data[7:0], vblank_irq[8], stat_irq[9], zeros above
);

	logic    valid_s1;
	item_t   item_s1;
	logic    can_load;
	logic    advance;
	result_t res;

	assign advance = valid_s1 && can_load;

	lcdts_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lcdts_engine #(
		.LINE_CYCLES   (LINE_CYCLES),
		.VISIBLE_LINES (VISIBLE_LINES),
		.LAST_LINE     (LAST_LINE)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res)
	);

	lcdts_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.res        (res),
		.can_load   (can_load),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
